[hdl/kdpc_pkg.sv]
// Shared types and constants for the keypad debounce and press control block.
package kdpc_pkg;

  // Field widths fixed by the word formats
  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 10;
  localparam int KEY_IDX_W = 4;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK    = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_W-1:0] BLINK_RESET    = 16'd150;

  // Input word kinds
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_CAPTURE = 1'b1;

  // Action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [TIME_W-1:0]  now_ms;
    logic [LEVEL_W-1:0] levels;
    logic               playing;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   pressed_mask;
    logic [KEY_IDX_W-1:0] press_key;
    logic [1:0]           action;
    logic                 led;
  } out_word_t;

  // Step request from the top level to the key bank
  typedef struct packed {
    logic               go;
    logic               capture;
    logic [TIME_W-1:0]  now_ms;
    logic [LEVEL_W-1:0] levels;
  } kdpc_step_t;

  // Press report from the key bank
  typedef struct packed {
    logic                 found;
    logic [KEY_IDX_W-1:0] first;
    logic [LEVEL_W-1:0]   mask;
  } kdpc_press_t;

endpackage

[hdl/keypad_debounce_press_control.sv]
// Top level: handshake stages, configuration registers, status LED and action decode.
//
// Takes one sample word per cycle unless stalled and returns one result word per
// sample. A word is held in the input register, then the key bank and LED logic
// resolve it into the output register. Both stages advance together, so samples
// flow back to back until the result side stalls; a stalled result holds the output
// register while the input register still takes one more word. A capture word
// reloads all key levels and timers and drives the LED off. Timers compare 32-bit
// millisecond stamps modulo 2^32 against the 16-bit debounce and blink registers,
// which the user must write only while no word is in flight; it is not checked.
module keypad_debounce_press_control import kdpc_pkg::*; #(
  parameter int NUM_KEYS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word
);

  logic [CFG_W-1:0]  debounce_r;
  logic [CFG_W-1:0]  blink_r;
  logic              in_valid_r;
  in_word_t          in_word_r;
  logic              out_valid_r;
  out_word_t         out_word_r, out_word_nxt;
  logic              led_r, led_nxt;
  logic [TIME_W-1:0] ltime_r, ltime_nxt;
  logic              out_free;
  logic              advance;
  logic              capture;
  kdpc_step_t        step;
  kdpc_press_t       press;

  // Stage handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign capture   = in_word_r.kind == KIND_CAPTURE;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      blink_r    <= BLINK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_r <= cfg_wdata;
        CFG_BLINK:    blink_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
  end

  // Drive the key bank
  assign step.go      = advance;
  assign step.capture = capture;
  assign step.now_ms  = in_word_r.now_ms;
  assign step.levels  = in_word_r.levels;

  kdpc_keys #(
    .NUM_KEYS(NUM_KEYS)
  ) u_keys (
    .clk     (clk),
    .rst_n   (rst_n),
    .hold_ms (debounce_r),
    .step    (step),
    .press   (press)
  );

  // Advance the LED blink and build the result word
  always_comb begin
    led_nxt      = led_r;
    ltime_nxt    = ltime_r;
    out_word_nxt = '0;
    if (advance) begin
      if (capture) begin
        led_nxt = 1'b0;
      end else if (!in_word_r.playing) begin
        led_nxt = 1'b0;
      end else if ((in_word_r.now_ms - ltime_r) >=
                   {{(TIME_W-CFG_W){1'b0}}, blink_r}) begin
        led_nxt   = ~led_r;
        ltime_nxt = in_word_r.now_ms;
      end
    end
    if (!capture) begin
      out_word_nxt.pressed_mask = press.mask;
      out_word_nxt.press_key    = press.first;
      if (press.found) begin
        out_word_nxt.action = in_word_r.playing ? ACT_STOP : ACT_START;
      end else begin
        out_word_nxt.action = ACT_NONE;
      end
      out_word_nxt.led = led_nxt;
    end
  end

  // Hold LED state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r   <= 1'b0;
      ltime_r <= '0;
    end else begin
      led_r   <= led_nxt;
      ltime_r <= ltime_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

[hdl/kdpc_keys.sv]
// Key bank: per-key raw/stable level tracking, debounce timers and press encoding.
module kdpc_keys import kdpc_pkg::*; #(
  parameter int NUM_KEYS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CFG_W-1:0]  hold_ms,
  input  kdpc_step_t        step,
  output kdpc_press_t       press
);

  logic [NUM_KEYS-1:0] raw_r,    raw_nxt;
  logic [NUM_KEYS-1:0] stable_r, stable_nxt;
  logic [TIME_W-1:0]   ctime_r  [NUM_KEYS];
  logic [TIME_W-1:0]   ctime_nxt[NUM_KEYS];
  logic [NUM_KEYS-1:0] lvl;
  logic [NUM_KEYS-1:0] hit;

  // Extend sampled levels; keys past the field read as pressed
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lvl
    if (k < LEVEL_W) begin : g_in
      assign lvl[k] = step.levels[k];
    end else begin : g_out
      assign lvl[k] = 1'b0;
    end
  end

  // Per-key timer check and stable update, all keys in parallel
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    logic              moved;
    logic [TIME_W-1:0] held;
    logic              settle;

    assign moved  = lvl[k] != raw_r[k];
    assign held   = moved ? '0 : step.now_ms - ctime_r[k];
    assign settle = (held >= {{(TIME_W-CFG_W){1'b0}}, hold_ms}) &&
                    (lvl[k] != stable_r[k]);

    always_comb begin
      raw_nxt[k]    = raw_r[k];
      stable_nxt[k] = stable_r[k];
      ctime_nxt[k]  = ctime_r[k];
      hit[k]        = 1'b0;
      if (step.go) begin
        if (step.capture) begin
          raw_nxt[k]    = lvl[k];
          stable_nxt[k] = lvl[k];
          ctime_nxt[k]  = step.now_ms;
        end else begin
          raw_nxt[k] = lvl[k];
          if (moved) begin
            ctime_nxt[k] = step.now_ms;
          end
          if (settle) begin
            stable_nxt[k] = lvl[k];
            hit[k]        = ~lvl[k];
          end
        end
      end
    end
  end

  // Hold key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= '1;
      stable_r <= '1;
      for (int k = 0; k < NUM_KEYS; k++) begin
        ctime_r[k] <= '0;
      end
    end else begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      for (int k = 0; k < NUM_KEYS; k++) begin
        ctime_r[k] <= ctime_nxt[k];
      end
    end
  end

  // Pick the lowest-index press
  always_comb begin
    press.found = |hit;
    press.first = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        press.first = KEY_IDX_W'(k);
      end
    end
  end

  // Report presses that fit the mask field
  for (genvar b = 0; b < LEVEL_W; b++) begin : g_mask
    if (b < NUM_KEYS) begin : g_in
      assign press.mask[b] = hit[b];
    end else begin : g_out
      assign press.mask[b] = 1'b0;
    end
  end

endmodule

[test/kdpc_press_checker.sv]
// Checker for the keypad debounce block: predicts each result word and compares it.
`timescale 1ns / 1ps

module kdpc_press_checker import kdpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_word,
  output int                   mismatches,
  output int                   pending_words
);

  localparam int KEYS = LEVEL_W;

  // Predicted block state and register copies
  logic [CFG_W-1:0]   hold_ms;
  logic [CFG_W-1:0]   blink_ms;
  logic [LEVEL_W-1:0] raw_lv;
  logic [LEVEL_W-1:0] stable_lv;
  logic [TIME_W-1:0]  changed_at [KEYS];
  logic               led_lit;
  logic [TIME_W-1:0]  led_flip_at;

  out_word_t expected_words [$];
  out_word_t want;

  // Advance the key timers by one word and return the press report it causes
  function automatic out_word_t debounce_sample(input in_word_t w);
    out_word_t         r;
    logic              found;
    logic [TIME_W-1:0] elapsed;
    r     = '0;
    found = 1'b0;
    if (w.kind == KIND_CAPTURE) begin
      // Power-up capture: take levels as stable, restart every timer, LED off
      raw_lv    = w.levels;
      stable_lv = w.levels;
      for (int k = 0; k < KEYS; k++) changed_at[k] = w.now_ms;
      led_lit = 1'b0;
      return r;
    end
    for (int k = 0; k < KEYS; k++) begin
      if (w.levels[k] != raw_lv[k]) begin
        raw_lv[k]     = w.levels[k];
        changed_at[k] = w.now_ms;
      end
      elapsed = w.now_ms - changed_at[k];
      if (elapsed >= hold_ms && w.levels[k] != stable_lv[k]) begin
        stable_lv[k] = w.levels[k];
        if (!w.levels[k]) begin
          r.pressed_mask[k] = 1'b1;
          if (!found) begin
            found       = 1'b1;
            r.press_key = KEY_IDX_W'(k);
          end
        end
      end
    end
    if (found) r.action = w.playing ? ACT_STOP : ACT_START;
    // Blink only while playing; drop the LED otherwise
    elapsed = w.now_ms - led_flip_at;
    if (!w.playing) begin
      led_lit = 1'b0;
    end else if (elapsed >= blink_ms) begin
      led_flip_at = w.now_ms;
      led_lit     = ~led_lit;
    end
    r.led = led_lit;
    return r;
  endfunction

  // Watch both channels; retire results before taking new words
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_ms     = DEBOUNCE_RESET;
      blink_ms    = BLINK_RESET;
      raw_lv      = '1;
      stable_lv   = '1;
      for (int k = 0; k < KEYS; k++) changed_at[k] = '0;
      led_lit     = 1'b0;
      led_flip_at = '0;
      mismatches  = 0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result mask=%h key=%0d action=%0d led=%0d", $time,
                     out_word.pressed_mask, out_word.press_key, out_word.action, out_word.led);
        end else begin
          want = expected_words.pop_front();
          if (out_word !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp mask=%h key=%0d action=%0d led=%0d", $time,
                       want.pressed_mask, want.press_key, want.action, want.led);
              $display("%0t:          got mask=%h key=%0d action=%0d led=%0d", $time,
                       out_word.pressed_mask, out_word.press_key, out_word.action,
                       out_word.led);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE: hold_ms = cfg_wdata;
          CFG_BLINK:    blink_ms = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_words.push_back(debounce_sample(in_word));
    end
    pending_words = expected_words.size();
  end

endmodule

[test/tb.sv]
// Testbench top: drives samples and register writes into the keypad debounce block.
`timescale 1ns / 1ps

module tb;
  import kdpc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 280;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;

  int mismatches;
  int pending_words;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;

  // Sample generator state
  logic [TIME_W-1:0]  clock_ms;
  logic [LEVEL_W-1:0] target_lv;
  logic [LEVEL_W-1:0] last_flip;
  logic               playing_now;
  int                 bounce_left;
  logic [CFG_W-1:0]   cur_hold;

  keypad_debounce_press_control u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  kdpc_press_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the result side at random while gaps are enabled
  always @(posedge clk) begin
    out_stall <= rst_n && gaps_on && ($urandom_range(0, 99) < 32);
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Present one word, with random idle cycles ahead of it, and hold until taken
  task automatic drive_word(input in_word_t w);
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send(input logic kind, input logic [TIME_W-1:0] now,
                      input logic [LEVEL_W-1:0] lv, input logic play);
    in_word_t w;
    w.kind    = kind;
    w.now_ms  = now;
    w.levels  = lv;
    w.playing = play;
    drive_word(w);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // Issue one register write; the caller drops the enable after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Build the next random word: mostly clean presses and releases with bounce
  task automatic random_word();
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      clock_ms = clock_ms + $urandom;
    end else if (pick >= 14) begin
      clock_ms = clock_ms + $urandom_range(0, cur_hold / 3 + 2);
    end
    if ($urandom_range(0, 99) < 5) playing_now = ~playing_now;
    w.kind    = KIND_SAMPLE;
    w.now_ms  = clock_ms;
    w.playing = playing_now;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      // Power-up capture with random held keys
      w.kind    = KIND_CAPTURE;
      w.levels  = LEVEL_W'($urandom_range(0, 1023));
      w.playing = 1'($urandom_range(0, 1));
      target_lv = w.levels;
      bounce_left = 0;
    end else if (pick < 13) begin
      // Noise: arbitrary levels and playing flag
      w.levels  = LEVEL_W'($urandom_range(0, 1023));
      w.playing = 1'($urandom_range(0, 1));
    end else begin
      if (bounce_left == 0 && $urandom_range(0, 99) < 20) begin
        last_flip = LEVEL_W'(1) << $urandom_range(0, LEVEL_W - 1);
        if ($urandom_range(0, 99) < 30)
          last_flip = last_flip | (LEVEL_W'(1) << $urandom_range(0, LEVEL_W - 1));
        target_lv   = target_lv ^ last_flip;
        bounce_left = $urandom_range(0, 4);
      end
      w.levels = target_lv;
      if (bounce_left > 0) begin
        bounce_left--;
        if ($urandom_range(0, 1)) w.levels = target_lv ^ last_flip;
      end
    end
    drive_word(w);
  endtask

  initial begin
    logic [CFG_W-1:0] hold_set  [PHASES];
    logic [CFG_W-1:0] blink_set [PHASES];
    hold_set  = '{16'd0, 16'd65535, 16'd1, 16'd20, 16'd0, 16'd50};
    blink_set = '{16'd65535, 16'd0, 16'd150, 16'd1, 16'd0, 16'd7};
    hold_set[4]  = CFG_W'($urandom_range(0, 300));
    blink_set[4] = CFG_W'($urandom_range(0, 400));
    playing_now = 1'b0;
    bounce_left = 0;
    last_flip   = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers, debounce edge, capture of held keys, wrap, blink
    send(KIND_SAMPLE,  32'd0,          10'h3FF, 1'b0);
    send(KIND_SAMPLE,  32'd49,         10'h3FE, 1'b0);
    send(KIND_SAMPLE,  32'd98,         10'h3FE, 1'b0);
    send(KIND_SAMPLE,  32'd99,         10'h3FE, 1'b1);
    send(KIND_CAPTURE, 32'hFFFF_FF00,  10'h00F, 1'b1);
    send(KIND_SAMPLE,  32'hFFFF_FFD0,  10'h000, 1'b0);
    send(KIND_SAMPLE,  32'h0000_0002,  10'h000, 1'b0);
    send(KIND_SAMPLE,  32'h0000_0010,  10'h3FF, 1'b1);
    send(KIND_SAMPLE,  32'h0000_0042,  10'h3FF, 1'b1);
    send(KIND_SAMPLE,  32'h0000_0096,  10'h1FF, 1'b1);
    send(KIND_SAMPLE,  32'h0000_00C8,  10'h1FF, 1'b1);
    send(KIND_SAMPLE,  32'h0000_012C,  10'h3FF, 1'b1);
    send(KIND_SAMPLE,  32'h0000_0130,  10'h3FF, 1'b0);
    // Bouncing key that settles exactly when the hold time is reached
    send(KIND_SAMPLE,  32'h0000_0200,  10'h3DF, 1'b0);
    send(KIND_SAMPLE,  32'h0000_0210,  10'h3FF, 1'b0);
    send(KIND_SAMPLE,  32'h0000_0220,  10'h3DF, 1'b0);
    send(KIND_SAMPLE,  32'h0000_0251,  10'h3DF, 1'b0);
    send(KIND_SAMPLE,  32'h0000_0252,  10'h3DF, 1'b0);
    send(KIND_SAMPLE,  32'hFFFF_FFFF,  10'h3FF, 1'b1);
    send(KIND_CAPTURE, 32'h0000_0000,  10'h000, 1'b0);
    send(KIND_SAMPLE,  32'h0000_0040,  10'h3FF, 1'b1);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      cur_hold = hold_set[p];
      write_reg(CFG_DEBOUNCE, hold_set[p]);
      write_reg(CFG_BLINK, blink_set[p]);
      cfg_we   <= 1'b0;
      gaps_on  = (p != 1);
      clock_ms = (p == 3) ? 32'hFFFF_F000 : $urandom;
      target_lv = LEVEL_W'($urandom_range(0, 1023));
      send(KIND_CAPTURE, clock_ms, target_lv, 1'b0);
      for (int n = 0; n < PHASE_WORDS; n++) random_word();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_words == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
